// ===== design/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// Nearest palette color search package
// Widths, codes and defaults shared by the palette search block and its
// channel interfaces.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam int CHAN_W   = 8;
    localparam int COLOR_W  = 3 * CHAN_W;
    localparam int INDEX_W  = 8;
    localparam int WEIGHT_W = 8;
    localparam int SQ_W     = 2 * CHAN_W;
    localparam int PROD_W   = WEIGHT_W + SQ_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int BEST_W   = SUM_W + 1;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd1;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REG_RED_WEIGHT   = 2'd0,
        REG_GREEN_WEIGHT = 2'd1,
        REG_BLUE_WEIGHT  = 2'd2
    } t_reg_idx;

endpackage

// ===== design/nps_in_if.sv =====
// ----------------------------------------------------------------------------
// Palette search input channel
// Carries palette writes and color queries with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface nps_in_if;
    import nps_pkg::*;

    logic                valid;
    logic                ready;
    logic                operation;
    logic [INDEX_W-1:0]  entry_index;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;

    modport source (
        output valid, operation, entry_index, red, green, blue,
        input  ready
    );

    modport sink (
        input  valid, operation, entry_index, red, green, blue,
        output ready
    );
endinterface

// ===== design/nps_out_if.sv =====
// ----------------------------------------------------------------------------
// Palette search result channel
// Carries the nearest palette index and the exact match flag.
// ----------------------------------------------------------------------------
interface nps_out_if;
    import nps_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] best_index;
    logic               exact_match;

    modport source (
        output valid, best_index, exact_match,
        input  ready
    );

    modport sink (
        input  valid, best_index, exact_match,
        output ready
    );
endinterface

// ===== design/nps_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/nearest_palette_color_search_core.sv =====
// ----------------------------------------------------------------------------
// Nearest palette color search core
// Holds an RGB palette and returns the first entry of least weighted squared
// distance to a query color, or entry 0 when none is under twice the distance
// to black, scanning one entry per cycle through a pipelined distance unit.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                Beat contents
//  i_in      in         valid/ready              operation, entry_index, rgb
//  o_out     out        valid/ready              best_index, exact_match
//  apb       in         psel/penable/pready      color channel weights
//
//  A palette write gives no result beat.
//  A query scans the palette, stopping early on an exact match; the single RAM
//  read port paces the scan at one entry per cycle, and the distance unit
//  registers the squares, the weighted products and their sum.
//  The input is ready only when idle, not during a scan nor while a result
//  waits for the output register. Once there, the next item is taken while it waits.
//  Reset is synchronous; the palette has no clearing pass.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_core #(
    parameter int PALETTE_ENTRIES = nps_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nps_in_if.sink                        i_in,
    nps_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nps_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [nps_pkg::APB_DATA_W-1:0] pwdata,
    output logic [nps_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);
    import nps_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [WEIGHT_W-1:0] r_w_red;
    logic [WEIGHT_W-1:0] r_w_green;
    logic [WEIGHT_W-1:0] r_w_blue;

    logic [CHAN_W-1:0] r_tr;
    logic [CHAN_W-1:0] r_tg;
    logic [CHAN_W-1:0] r_tb;

    logic          r_issue;
    logic          r_bound_first;
    logic [AW-1:0] r_addr;

    logic          r_v0, r_v1, r_v2, r_v3;
    logic          r_b0, r_b1, r_b2, r_b3;
    logic [AW-1:0] r_i0, r_i1, r_i2, r_i3;

    logic [SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b;
    logic [PROD_W-1:0] r_p_r, r_p_g, r_p_b;
    logic [SUM_W-1:0]  r_sum;

    logic [BEST_W-1:0] r_best;
    logic [AW-1:0]     r_best_idx;
    logic              r_exact;

    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_idx;
    logic               r_out_exact;

    logic               in_ready;
    logic               in_fire;
    logic               wr_fire;
    logic               query_fire;
    logic               ram_we;
    logic [COLOR_W-1:0] ram_rdata;
    logic [COLOR_W-1:0] cand;
    logic [CHAN_W-1:0]  d_r, d_g, d_b;
    logic               hit;
    logic               exact_hit;
    logic               pipe_empty;
    logic               scan_done;
    logic               out_free;
    logic               cfg_we;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_red   <= WEIGHT_RESET;
            r_w_green <= WEIGHT_RESET;
            r_w_blue  <= WEIGHT_RESET;
        end else if (cfg_we) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_RED_WEIGHT:   r_w_red   <= pwdata[WEIGHT_W-1:0];
                REG_GREEN_WEIGHT: r_w_green <= pwdata[WEIGHT_W-1:0];
                REG_BLUE_WEIGHT:  r_w_blue  <= pwdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_RED_WEIGHT:   prdata = APB_DATA_W'(r_w_red);
            REG_GREEN_WEIGHT: prdata = APB_DATA_W'(r_w_green);
            REG_BLUE_WEIGHT:  prdata = APB_DATA_W'(r_w_blue);
            default:          prdata = '0;
        endcase
    end

    // Input handshake and palette writes.
    assign in_ready   = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && in_ready;
    assign wr_fire    = in_fire && (t_op'(i_in.operation) == OP_WRITE);
    assign query_fire = in_fire && (t_op'(i_in.operation) == OP_QUERY);
    assign ram_we     = wr_fire && (32'(i_in.entry_index) < 32'(PALETTE_ENTRIES));
    assign i_in.ready = in_ready;

    nps_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_in.entry_index)),
        .i_wdata ({i_in.red, i_in.green, i_in.blue}),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Distance unit. The first beat of a scan carries black to form the bound.
    assign cand = r_b0 ? '0 : ram_rdata;
    assign d_r  = (r_tr > cand[23:16]) ? r_tr - cand[23:16] : cand[23:16] - r_tr;
    assign d_g  = (r_tg > cand[15:8])  ? r_tg - cand[15:8]  : cand[15:8]  - r_tg;
    assign d_b  = (r_tb > cand[7:0])   ? r_tb - cand[7:0]   : cand[7:0]   - r_tb;

    always_ff @(posedge i_clk) begin
        r_i0   <= r_addr;
        r_b0   <= r_bound_first;
        r_sq_r <= SQ_W'(d_r) * SQ_W'(d_r);
        r_sq_g <= SQ_W'(d_g) * SQ_W'(d_g);
        r_sq_b <= SQ_W'(d_b) * SQ_W'(d_b);
        r_i1   <= r_i0;
        r_b1   <= r_b0;
        r_p_r  <= PROD_W'(r_w_red)   * PROD_W'(r_sq_r);
        r_p_g  <= PROD_W'(r_w_green) * PROD_W'(r_sq_g);
        r_p_b  <= PROD_W'(r_w_blue)  * PROD_W'(r_sq_b);
        r_i2   <= r_i1;
        r_b2   <= r_b1;
        r_sum  <= SUM_W'(r_p_r) + SUM_W'(r_p_g) + SUM_W'(r_p_b);
        r_i3   <= r_i2;
        r_b3   <= r_b2;
    end

    // Running best compare.
    assign hit        = r_v3 && !r_b3 && (BEST_W'(r_sum) < r_best);
    assign exact_hit  = hit && (r_sum == '0);
    assign pipe_empty = !r_v0 && !r_v1 && !r_v2 && !r_v3;
    assign scan_done  = !r_issue && pipe_empty;
    assign out_free   = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (r_v3 && r_b3) begin
            r_best     <= {r_sum, 1'b0};
            r_best_idx <= '0;
        end else if (hit) begin
            r_best     <= BEST_W'(r_sum);
            r_best_idx <= r_i3;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (query_fire) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (exact_hit || scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_issue       <= 1'b0;
            r_bound_first <= 1'b0;
            r_addr        <= '0;
            r_v0          <= 1'b0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_exact       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (query_fire) begin
                r_tr          <= i_in.red;
                r_tg          <= i_in.green;
                r_tb          <= i_in.blue;
                r_issue       <= 1'b1;
                r_bound_first <= 1'b1;
                r_addr        <= '0;
                r_exact       <= 1'b0;
            end else if (exact_hit) begin
                r_issue <= 1'b0;
                r_exact <= 1'b1;
            end else if (r_issue) begin
                if (r_bound_first) begin
                    r_bound_first <= 1'b0;
                end else if (r_addr == AW'(PALETTE_ENTRIES - 1)) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end

            r_v0 <= r_issue && !exact_hit;
            r_v1 <= r_v0 && !exact_hit;
            r_v2 <= r_v1 && !exact_hit;
            r_v3 <= r_v2 && !exact_hit;

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_out_idx   <= INDEX_W'(r_best_idx);
                r_out_exact <= r_exact;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.best_index  = r_out_idx;
    assign o_out.exact_match = r_out_exact;
endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Nearest palette color search testbench
// Loads the palette through write beats and sends color queries. Each query
// is checked against a result given with it or one predicted at the moment it
// is accepted, from a local copy of the palette and of the channel weights.
// Directed queries come first, then random phases under several weight
// settings. Both sides idle at random, and the receiver once holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb;
    import nps_pkg::*;

    localparam int          PALETTE_ENTRIES = PALETTE_ENTRIES_DEF;
    localparam int          IDLE_PCT        = 22;
    localparam int          SETTLE_CYCLES   = 16;
    localparam int          HOLD_CYCLES     = 1000;
    localparam int          WATCHDOG_LIMIT  = 8000;
    localparam int          MAX_REPORTS     = 10;
    localparam int          DIR_ROWS        = 24;
    localparam int          PHASES          = 5;
    localparam int          PHASE_ITEMS     = 165;
    localparam logic [31:0] BOUND_SCALE     = 32'd2;
    localparam logic [1:0]  REG_UNUSED      = 2'd3;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } t_rgb;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               exact;
    } t_match;

    typedef struct packed {
        bit     typed;
        t_match result;
    } t_item_tag;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_QUERY,
        ROW_CONFIG
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [INDEX_W-1:0] sel;
        t_rgb               color;
        bit                 typed;
        t_match             result;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    nps_in_if  in_if ();
    nps_out_if out_if ();

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    t_rgb                palette_model [PALETTE_ENTRIES];
    logic [WEIGHT_W-1:0] w_red   = WEIGHT_RESET;
    logic [WEIGHT_W-1:0] w_green = WEIGHT_RESET;
    logic [WEIGHT_W-1:0] w_blue  = WEIGHT_RESET;

    t_item_tag   offered_q [$];
    t_match      match_q [$];
    int unsigned fail_count = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;

    // For a config row, color carries the red, green and blue weights.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_QUERY,  8'd0,   '{8'd1,   8'd1,   8'd1},   1'b1, '{8'd0,   1'b0}},
        '{ROW_QUERY,  8'd255, '{8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   1'b0}},
        '{ROW_QUERY,  8'd7,   '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0,   1'b1}},
        '{ROW_WRITE,  8'd255, '{8'd10,  8'd20,  8'd30},  1'b0, '{8'd0,   1'b0}},
        '{ROW_QUERY,  8'd0,   '{8'd10,  8'd20,  8'd30},  1'b1, '{8'd255, 1'b1}},
        '{ROW_WRITE,  8'd0,   '{8'd0,   8'd0,   8'd0},   1'b0, '{8'd0,   1'b0}},
        '{ROW_QUERY,  8'd0,   '{8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   1'b0}},
        '{ROW_WRITE,  8'd128, '{8'd10,  8'd20,  8'd31},  1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE,  8'd200, '{8'd10,  8'd20,  8'd33},  1'b0, '{8'd0,   1'b0}},
        '{ROW_QUERY,  8'd0,   '{8'd10,  8'd20,  8'd32},  1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE,  8'd1,   '{8'd255, 8'd0,   8'd255}, 1'b0, '{8'd0,   1'b0}},
        '{ROW_QUERY,  8'd0,   '{8'd255, 8'd0,   8'd255}, 1'b1, '{8'd1,   1'b1}},
        '{ROW_WRITE,  8'd2,   '{8'd0,   8'd255, 8'd0},   1'b0, '{8'd0,   1'b0}},
        '{ROW_QUERY,  8'd0,   '{8'd0,   8'd255, 8'd0},   1'b1, '{8'd2,   1'b1}},
        '{ROW_CONFIG, 8'd0,   '{8'd0,   8'd0,   8'd0},   1'b0, '{8'd0,   1'b0}},
        '{ROW_QUERY,  8'd0,   '{8'd255, 8'd0,   8'd255}, 1'b1, '{8'd0,   1'b0}},
        '{ROW_QUERY,  8'd0,   '{8'd12,  8'd34,  8'd56},  1'b1, '{8'd0,   1'b0}},
        '{ROW_CONFIG, 8'd0,   '{8'd255, 8'd255, 8'd255}, 1'b0, '{8'd0,   1'b0}},
        '{ROW_QUERY,  8'd0,   '{8'd10,  8'd20,  8'd32},  1'b0, '{8'd0,   1'b0}},
        '{ROW_QUERY,  8'd0,   '{8'd255, 8'd255, 8'd255}, 1'b0, '{8'd0,   1'b0}},
        '{ROW_CONFIG, 8'd0,   '{8'd0,   8'd255, 8'd1},   1'b0, '{8'd0,   1'b0}},
        '{ROW_QUERY,  8'd0,   '{8'd200, 8'd20,  8'd32},  1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE,  8'd254, '{8'd0,   8'd0,   8'd1},   1'b0, '{8'd0,   1'b0}},
        '{ROW_QUERY,  8'd0,   '{8'd0,   8'd0,   8'd1},   1'b0, '{8'd0,   1'b0}}
    };

    t_rgb phase_weights [PHASES-1] = '{
        '{8'd1,   8'd1,   8'd1},
        '{8'd255, 8'd255, 8'd255},
        '{8'd1,   8'd0,   8'd0},
        '{8'd0,   8'd255, 8'd3}
    };

    nearest_palette_color_search_core #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    function automatic logic [31:0] weighted_dist(t_rgb a, t_rgb c);
        logic [31:0] dr, dg, db;
        dr = (a.r > c.r) ? a.r - c.r : c.r - a.r;
        dg = (a.g > c.g) ? a.g - c.g : c.g - a.g;
        db = (a.b > c.b) ? a.b - c.b : c.b - a.b;
        return w_red * dr * dr + w_green * dg * dg + w_blue * db * db;
    endfunction

    // The scan starts from twice the distance to black, paired with index 0,
    // and only a strictly smaller distance takes over.
    function automatic t_match nearest_entry(t_rgb target);
        logic [31:0] bound, d;
        t_match      m;
        int          i;
        bound = BOUND_SCALE * weighted_dist(target, '0);
        m     = '0;
        for (i = 0; i < PALETTE_ENTRIES; i++) begin
            d = weighted_dist(target, palette_model[i]);
            if (d < bound) begin
                bound   = d;
                m.index = INDEX_W'(i);
                if (d == 0) begin
                    m.exact = 1'b1;
                    break;
                end
            end
        end
        return m;
    endfunction

    function automatic logic [CHAN_W-1:0] random_channel();
        int unsigned pick;
        pick = $urandom_range(3);
        return (pick == 0) ? '0 : (pick == 1) ? '1 : CHAN_W'($urandom());
    endfunction

    function automatic t_rgb random_color();
        return '{random_channel(), random_channel(), random_channel()};
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    task automatic send_item(input t_op op, input logic [INDEX_W-1:0] idx, input t_rgb c,
                             input bit typed, input t_match result);
        t_item_tag tag;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.operation   <= op;
        in_if.entry_index <= idx;
        in_if.red         <= c.r;
        in_if.green       <= c.g;
        in_if.blue        <= c.b;
        tag.typed  = typed;
        tag.result = result;
        offered_q.push_back(tag);
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (match_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] reg_sel, input logic [WEIGHT_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word                 = $urandom();
        word[WEIGHT_W-1:0]   = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(reg_sel) << 2;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (reg_sel)
            REG_RED_WEIGHT:   w_red = value;
            REG_GREEN_WEIGHT: w_green = value;
            REG_BLUE_WEIGHT:  w_blue = value;
            default: ;
        endcase
    endtask

    task automatic set_weights(input t_rgb w);
        settle();
        reg_write(REG_RED_WEIGHT, w.r);
        reg_write(REG_GREEN_WEIGHT, w.g);
        reg_write(REG_BLUE_WEIGHT, w.b);
    endtask

    task automatic send_random();
        t_rgb        c;
        int unsigned pick;
        pick = $urandom_range(99);
        c    = palette_model[$urandom_range(PALETTE_ENTRIES-1)];
        if (pick < 45) begin
            send_item(OP_WRITE, INDEX_W'($urandom()), random_color(), 1'b0, '0);
        end else begin
            // Most targets sit on or next to a stored color.
            if (pick >= 80) begin
                c = random_color();
            end else if (pick >= 65) begin
                c = t_rgb'(c ^ (24'h030303 & COLOR_W'($urandom())));
            end
            send_item(OP_QUERY, INDEX_W'($urandom()), c, 1'b0, '0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin : result_sink
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin : query_predict
        t_item_tag tag;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            tag = offered_q.pop_front();
            if (in_if.operation == OP_WRITE) begin
                palette_model[in_if.entry_index] = t_rgb'{in_if.red, in_if.green, in_if.blue};
            end else if (tag.typed) begin
                match_q.push_back(tag.result);
            end else begin
                match_q.push_back(nearest_entry(t_rgb'{in_if.red, in_if.green, in_if.blue}));
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_match want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (match_q.size() == 0) begin
                note_failure($sformatf("unexpected result beat: index %0d exact %0b",
                                       out_if.best_index, out_if.exact_match));
            end else begin
                want = match_q.pop_front();
                if (out_if.best_index !== want.index || out_if.exact_match !== want.exact) begin
                    note_failure($sformatf(
                        "result mismatch: expected index %0d exact %0b, got index %0d exact %0b",
                        want.index, want.exact, out_if.best_index, out_if.exact_match));
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        t_dir_row    row;
        t_rgb        w;
        int unsigned k, ph;
        in_if.valid       <= 1'b0;
        in_if.operation   <= OP_WRITE;
        in_if.entry_index <= '0;
        in_if.red         <= '0;
        in_if.green       <= '0;
        in_if.blue        <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        i_rst_n           <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every entry starts out white, so the first queries are easy to reason about.
        for (k = 0; k < PALETTE_ENTRIES; k++) begin
            send_item(OP_WRITE, INDEX_W'(k), '1, 1'b0, '0);
        end

        for (k = 0; k < DIR_ROWS; k++) begin
            row = dir_rows[k];
            case (row.kind)
                ROW_WRITE:  send_item(OP_WRITE, row.sel, row.color, 1'b0, '0);
                ROW_QUERY:  send_item(OP_QUERY, row.sel, row.color, row.typed, row.result);
                default:    set_weights(row.color);
            endcase
        end

        for (k = 0; k < PALETTE_ENTRIES; k++) begin
            send_item(OP_WRITE, INDEX_W'(k), random_color(), 1'b0, '0);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            w = (ph < PHASES - 1) ? phase_weights[ph] : t_rgb'(COLOR_W'($urandom()));
            set_weights(w);
            if (ph == 0) begin
                // A write past the last register must leave the weights alone.
                reg_write(REG_UNUSED, '0);
            end
            calm = (ph == 1);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 3 && k == 30) begin
                    hold_req = 1'b1;
                end
                send_random();
            end
        end

        calm = 1'b0;
        settle();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
